// ----- rtl/minmax_vector_normalizer_macros.svh -----
// Assertion helpers for the RTL of the normalizer.
`ifndef MINMAX_VECTOR_NORMALIZER_MACROS_SVH
`define MINMAX_VECTOR_NORMALIZER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked outside reset.
`define MMVN_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication, checked outside reset.
`define MMVN_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define MMVN_ASSERT_IMP(label, clk, rst, ante, cons)
`define MMVN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/mmvn_pkg.sv -----
package mmvn_pkg;

   localparam int DEPTH_DEFAULT       = 64;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Result format: unsigned Q1.15, so the quotient needs 16 bits.
   localparam int Q_BITS = 16;
   localparam int Q_ONE  = 32768;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RANGE,
      ST_FETCH,
      ST_DIFF,
      ST_START,
      ST_DIV,
      ST_PUT
   } state_type;

endpackage

// ----- rtl/minmax_vector_normalizer.sv -----
// Min-max vector normalizer.
// Input channel req_*: one signed sample per item, req_last_in marks the end of
// a vector. Samples are taken one per cycle while the block is loading.
// A vector ends on an item with req_last_in set or on the DEPTH-th item.
// Then req_stall rises and every stored sample is sent on rsp_* in arrival
// order as (x - min) / (max - min) in unsigned Q1.15, rounded to nearest.
// rsp_last_out marks the final result; rsp_degenerate is set with a zero
// result when all samples of the vector were equal.
// Steps: after the closing item, a range step computes max - min; each result
// then goes through memory read, offset, divider start, a bit-serial restoring
// divider for 16 quotient bits and its done flag, and output load; a degenerate
// vector skips the divider. Results are made one at a time, not overlapped.
// The result sits in an output register; a stall holds it and the sequencer
// waits there. Loading of the next vector starts while the last result of the
// previous one still waits to be taken.
// Reset (synchronous) empties the vector and clears all handshake state; the
// sample memory itself is not cleared.
module minmax_vector_normalizer #(
   parameter int DEPTH       = mmvn_pkg::DEPTH_DEFAULT,
   parameter int SAMPLE_BITS = mmvn_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample,
   input  logic                                req_last_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [mmvn_pkg::Q_BITS-1:0]         rsp_scaled,
   output logic                                rsp_degenerate,
   output logic                                rsp_last_out
);

`include "minmax_vector_normalizer_macros.svh"

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int QB = mmvn_pkg::Q_BITS;

   localparam logic signed [SAMPLE_BITS-1:0] MostPos = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] MostNeg = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   mmvn_pkg::state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] sample_store_ff [DEPTH];
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;

   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 k_ff, k_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic [SAMPLE_BITS-1:0]        range_ff, range_in;
   logic                          degen_ff, degen_in;
   logic [SAMPLE_BITS-1:0]        diff_ff, diff_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [QB-1:0]                 rsp_scaled_ff, rsp_scaled_in;
   logic                          rsp_degenerate_ff, rsp_degenerate_in;
   logic                          rsp_last_out_ff, rsp_last_out_in;

   logic                          in_take;
   logic                          closes;
   logic                          out_free;
   logic                          last_elem;
   logic                          div_start;
   logic                          div_done;
   logic [QB-1:0]                 div_quot;
   logic signed [SAMPLE_BITS:0]   span;
   logic signed [SAMPLE_BITS:0]   offset;

   assign req_stall = (state_ff != mmvn_pkg::ST_LOAD);
   assign in_take   = req_valid && !req_stall;
   assign closes    = req_last_in || (count_ff == CW'(DEPTH - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_elem = ((CW'(k_ff) + 1'b1) == count_ff);
   assign span      = {max_ff[SAMPLE_BITS-1], max_ff} - {min_ff[SAMPLE_BITS-1], min_ff};
   assign offset    = {rd_data_ff[SAMPLE_BITS-1], rd_data_ff}
                      - {min_ff[SAMPLE_BITS-1], min_ff};

   mmvn_div #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(diff_ff),
      .divisor (range_ff),
      .done    (div_done),
      .quotient(div_quot)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mmvn_pkg::ST_LOAD:  if (in_take && closes) state_in = mmvn_pkg::ST_RANGE;
         mmvn_pkg::ST_RANGE: state_in = mmvn_pkg::ST_FETCH;
         mmvn_pkg::ST_FETCH: state_in = mmvn_pkg::ST_DIFF;
         mmvn_pkg::ST_DIFF:  state_in = mmvn_pkg::ST_START;
         mmvn_pkg::ST_START: state_in = degen_ff ? mmvn_pkg::ST_PUT : mmvn_pkg::ST_DIV;
         mmvn_pkg::ST_DIV:   if (div_done) state_in = mmvn_pkg::ST_PUT;
         mmvn_pkg::ST_PUT: begin
            if (out_free) begin
               state_in = last_elem ? mmvn_pkg::ST_LOAD : mmvn_pkg::ST_FETCH;
            end
         end
         default:            state_in = mmvn_pkg::ST_LOAD;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      count_in          = count_ff;
      k_in              = k_ff;
      min_in            = min_ff;
      max_in            = max_ff;
      range_in          = range_ff;
      degen_in          = degen_ff;
      diff_in           = diff_ff;
      div_start         = 1'b0;
      rsp_scaled_in     = rsp_scaled_ff;
      rsp_degenerate_in = rsp_degenerate_ff;
      rsp_last_out_in   = rsp_last_out_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         mmvn_pkg::ST_LOAD: begin
            if (in_take) begin
               count_in = count_ff + 1'b1;
               if (req_sample < min_ff) min_in = req_sample;
               if (req_sample > max_ff) max_in = req_sample;
               k_in = '0;
            end
         end
         mmvn_pkg::ST_RANGE: begin
            range_in = span[SAMPLE_BITS-1:0];
            degen_in = (span == '0);
         end
         mmvn_pkg::ST_FETCH: begin
         end
         mmvn_pkg::ST_DIFF: begin
            diff_in = offset[SAMPLE_BITS-1:0];
         end
         mmvn_pkg::ST_START: begin
            div_start = !degen_ff;
         end
         mmvn_pkg::ST_DIV: begin
         end
         mmvn_pkg::ST_PUT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_scaled_in     = degen_ff ? '0 : div_quot;
               rsp_degenerate_in = degen_ff;
               rsp_last_out_in   = last_elem;
               if (last_elem) begin
                  // Vector done: clear for the next one.
                  count_in = '0;
                  k_in     = '0;
                  min_in   = MostPos;
                  max_in   = MostNeg;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Sample memory: one write port while loading, one registered read port.
   always_ff @(posedge clock) begin
      if (in_take) begin
         sample_store_ff[count_ff[AW-1:0]] <= req_sample;
      end
      rd_data_ff <= sample_store_ff[k_ff];
   end

   always_ff @(posedge clock) begin
      range_ff          <= range_in;
      degen_ff          <= degen_in;
      diff_ff           <= diff_in;
      rsp_scaled_ff     <= rsp_scaled_in;
      rsp_degenerate_ff <= rsp_degenerate_in;
      rsp_last_out_ff   <= rsp_last_out_in;
      if (reset) begin
         state_ff     <= mmvn_pkg::ST_LOAD;
         count_ff     <= '0;
         k_ff         <= '0;
         min_ff       <= MostPos;
         max_ff       <= MostNeg;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         k_ff         <= k_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scaled     = rsp_scaled_ff;
   assign rsp_degenerate = rsp_degenerate_ff;
   assign rsp_last_out   = rsp_last_out_ff;

   `MMVN_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid && rsp_degenerate, rsp_scaled == '0)
   `MMVN_ASSERT_IMP(a_scaled_max, clock, reset, rsp_valid, rsp_scaled <= QB'(mmvn_pkg::Q_ONE))
   `MMVN_ASSERT_IMP(a_count_room, clock, reset, state_ff == mmvn_pkg::ST_LOAD, count_ff < CW'(DEPTH))
   `MMVN_ASSERT_IMP(a_div_done_state, clock, reset, div_done, state_ff == mmvn_pkg::ST_DIV)
   `MMVN_ASSERT_IMP(a_index_stored, clock, reset, state_ff == mmvn_pkg::ST_PUT, CW'(k_ff) < count_ff)
   `MMVN_ASSERT_NEXT(a_last_reload, clock, reset, rsp_valid_in && rsp_last_out_in && out_free && state_ff == mmvn_pkg::ST_PUT, count_ff == '0)

endmodule

// ----- rtl/mmvn_div.sv -----
module mmvn_div #(
   parameter int SAMPLE_BITS = mmvn_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [SAMPLE_BITS-1:0]        dividend,
   input  logic [SAMPLE_BITS-1:0]        divisor,
   output logic                          done,
   output logic [mmvn_pkg::Q_BITS-1:0]   quotient
);

   localparam int QB   = mmvn_pkg::Q_BITS;
   localparam int NW   = SAMPLE_BITS + QB;
   localparam int CNTW = $clog2(QB + 1);

   logic [SAMPLE_BITS-1:0] rem_ff, rem_in;
   logic [QB-1:0]          qr_ff, qr_in;
   logic [CNTW-1:0]        cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   logic [NW-1:0]          num;
   logic [SAMPLE_BITS:0]   trial;
   logic [SAMPLE_BITS:0]   trial_sub;
   logic                   fits;

   // Numerator is dividend * 2^15 plus half the divisor, for round to nearest.
   // Its top part is already below the divisor, so only 16 quotient bits remain.
   assign num       = {dividend, {(QB-1){1'b0}}} + NW'(divisor >> 1);
   assign trial     = {rem_ff, qr_ff[QB-1]};
   assign trial_sub = trial - {1'b0, divisor};
   assign fits      = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in  = rem_ff;
      qr_in   = qr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = num[NW-1:QB];
         qr_in   = num[QB-1:0];
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? trial_sub[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
         qr_in  = {qr_ff[QB-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNTW'(QB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      qr_ff  <= qr_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = qr_ff;

endmodule

// ----- sim/minmax_vector_normalizer_tb.sv -----
module minmax_vector_normalizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH          = mmvn_pkg::DEPTH_DEFAULT;
   localparam int SAMPLE_BITS    = mmvn_pkg::SAMPLE_BITS_DEFAULT;
   localparam int Q_BITS         = mmvn_pkg::Q_BITS;
   localparam int Q_ONE          = mmvn_pkg::Q_ONE;
   localparam int RANDOM_ITEMS   = 128;
   localparam int PHASE_CYCLES   = 1024;
   localparam int DRAIN_CYCLES   = 60;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last_in;
   } sample_item_type;

   typedef struct packed {
      logic [Q_BITS-1:0] scaled;
      logic              degenerate;
      logic              last_out;
   } norm_result_type;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample     = '0;
   logic                          req_last_in    = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic [Q_BITS-1:0]             rsp_scaled;
   logic                          rsp_degenerate;
   logic                          rsp_last_out;

   sample_item_type               pending_samples[$];
   norm_result_type               expected_results[$];
   logic signed [SAMPLE_BITS-1:0] vector_samples[$];
   logic signed [SAMPLE_BITS-1:0] vec_min = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   logic signed [SAMPLE_BITS-1:0] vec_max = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   int unsigned   mismatch_count = 0;
   int unsigned   cycle_count    = 0;
   int unsigned   quiet_cycles   = 0;
   idle_mode_type idle_mode;

   minmax_vector_normalizer #(
      .DEPTH       (DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample     (req_sample),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scaled     (rsp_scaled),
      .rsp_degenerate (rsp_degenerate),
      .rsp_last_out   (rsp_last_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // The idling pattern rotates through all four modes as the run goes on.
   assign idle_mode = idle_mode_type'((cycle_count / PHASE_CYCLES) % 4);

   function automatic bit roll(input int pct);
      return $urandom_range(99) < pct;
   endfunction

   function automatic int idle_pct(input bit sender_side);
      if (idle_mode == IDLE_BOTH)
         return 24;
      if (sender_side && idle_mode == IDLE_SENDER)
         return 88;
      if (!sender_side && idle_mode == IDLE_RECEIVER)
         return 88;
      return 0;
   endfunction

   // Adds one accepted sample to the vector under way; once the vector closes,
   // every element is rescaled against the vector's min and max.
   task automatic collect_and_normalize(input logic signed [SAMPLE_BITS-1:0] sample,
                                        input logic last);
      longint          span;
      longint          offset;
      longint          quotient;
      norm_result_type res;
      vector_samples.push_back(sample);
      if (sample < vec_min)
         vec_min = sample;
      if (sample > vec_max)
         vec_max = sample;
      if (last || vector_samples.size() >= DEPTH) begin
         span = longint'(vec_max) - longint'(vec_min);
         foreach (vector_samples[k]) begin
            quotient = 0;
            if (span != 0) begin
               offset   = longint'(vector_samples[k]) - longint'(vec_min);
               quotient = (offset * Q_ONE + span / 2) / span;
               if (quotient > Q_ONE)
                  quotient = Q_ONE;
            end
            res.scaled     = quotient[Q_BITS-1:0];
            res.degenerate = (span == 0);
            res.last_out   = (k == vector_samples.size() - 1);
            expected_results.push_back(res);
         end
         vector_samples.delete();
         vec_min = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         vec_max = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end
   endtask

   task automatic queue_sample(input int value, input bit last);
      sample_item_type item;
      item.sample  = value[SAMPLE_BITS-1:0];
      item.last_in = last;
      pending_samples.push_back(item);
   endtask

   task automatic queue_vector(input int values[$]);
      foreach (values[k])
         queue_sample(values[k], k == values.size() - 1);
   endtask

   task automatic build_stimulus();
      int vec_len;
      int shape;
      int base;
      int spread;
      int value;
      bit close_last;
      int random_count;
      queue_vector('{-32768});
      queue_vector('{32767});
      queue_vector('{-32768, 32767});
      queue_vector('{32767, -32768, 0, 1, -1});
      // All equal over several elements.
      queue_vector('{7, 7, 7});
      // Ranges of two and three: the second exercises round to nearest.
      queue_vector('{0, 1, 2});
      queue_vector('{0, 1, 3});
      queue_vector('{100, -100, 100, 0});

      random_count = 0;
      while (random_count < RANDOM_ITEMS) begin
         shape = $urandom_range(99);
         if (random_count == 0)
            vec_len = DEPTH;
         else if (shape < 70)
            vec_len = $urandom_range(8, 1);
         else if (shape < 92)
            vec_len = $urandom_range(24, 9);
         else
            vec_len = DEPTH;
         if (vec_len > RANDOM_ITEMS - random_count)
            vec_len = RANDOM_ITEMS - random_count;
         // A full store closes the vector whether or not last is set.
         close_last = (random_count == 0) ? 1'b0 : 1'($urandom_range(1));
         shape  = $urandom_range(9);
         spread = $urandom_range(255, 3);
         base   = $urandom_range(65535 - 255, 0) - 32768;
         for (int k = 0; k < vec_len; k++) begin
            if (shape < 5)
               value = $urandom_range(65535, 0) - 32768;
            else if (shape < 9)
               value = base + $urandom_range(spread, 0);
            else
               value = base;
            if (k == vec_len - 1)
               queue_sample(value, (vec_len == DEPTH) ? close_last : 1'b1);
            else
               queue_sample(value, 1'b0);
         end
         random_count += vec_len;
      end
   endtask

   always @(posedge clock) begin : drive_proc
      sample_item_type item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            collect_and_normalize(req_sample, req_last_in);
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() > 0 && !roll(idle_pct(1'b1))) begin
               item = pending_samples.pop_front();
               req_valid   <= 1'b1;
               req_sample  <= item.sample;
               req_last_in <= item.last_in;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor_proc
      norm_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected item, expected none, actual scaled %0d deg %0b last %0b",
                        $time, rsp_scaled, rsp_degenerate, rsp_last_out);
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_scaled !== want.scaled) begin
                  $display("%0t: scaled mismatch, expected %0d, actual %0d",
                           $time, want.scaled, rsp_scaled);
                  mismatch_count++;
               end
               if (rsp_degenerate !== want.degenerate) begin
                  $display("%0t: degenerate mismatch, expected %0b, actual %0b",
                           $time, want.degenerate, rsp_degenerate);
                  mismatch_count++;
               end
               if (rsp_last_out !== want.last_out) begin
                  $display("%0t: last_out mismatch, expected %0b, actual %0b",
                           $time, want.last_out, rsp_last_out);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= roll(idle_pct(1'b0));
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
   end

   initial begin
      build_stimulus();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      while (pending_samples.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
      // Any stray item would show up in this window.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
